>>> rtl/ddo_pkg.sv
// ---------------------------------------------------------------------------
// ddo_pkg: shared types and constants
// Fixed-point formats, register indexes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

    localparam int FracBits    = 16;
    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);

    localparam logic [1:0] REG_MPC  = 2'd0;
    localparam logic [1:0] REG_ITW  = 2'd1;
    localparam logic [1:0] REG_FW   = 2'd2;

    localparam logic [23:0] MPC_RESET = 24'd615683;
    localparam logic [19:0] ITW_RESET = 20'd119678;
    localparam logic [16:0] FW_RESET  = 17'd39322;

    localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
    localparam logic signed [31:0] RAD_TO_ANG = 32'sd2670177;

    typedef struct packed {
        logic        mode;
        logic [23:0] left_counts;
        logic [23:0] right_counts;
        logic [23:0] elapsed_time;
    } in_beat_t;

    typedef struct packed {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] heading;
        logic [31:0] step_x;
        logic [31:0] step_y;
        logic [31:0] step_heading;
        logic [31:0] linear_speed;
        logic [31:0] turn_rate;
        logic [31:0] left_speed;
        logic [31:0] right_speed;
        logic [31:0] left_filtered;
        logic [31:0] right_filtered;
    } out_beat_t;

    // Binary-angle arctangent of 2^-i.
    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/ddo_stream_if.sv
// ---------------------------------------------------------------------------
// ddo_stream_if: valid/ready channel
// Carries one payload beat per handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface ddo_in_if;
    logic             valid;
    logic             ready;
    ddo_pkg::in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ddo_out_if;
    logic              valid;
    logic              ready;
    ddo_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ddo_mac.sv
// ---------------------------------------------------------------------------
// ddo_mac: shared multiplier
// One signed 33x33 multiply with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none
module ddo_mac (
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      prod
);

    // Product register feeds the sequencer on the next cycle.
    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule
`default_nettype wire

>>> rtl/differential_drive_odometry.sv
// ---------------------------------------------------------------------------
// differential_drive_odometry: fixed-point dead-reckoning odometry
// Wheel beats update speeds and filters; tick beats integrate the pose.
// ---------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   mode, left_counts, right_counts, elapsed_time
//  out_ch    out  pose, steps, speeds, filtered speeds
//  cfg       in   cfg_we, cfg_index, cfg_data
//
// A wheel beat and a tick beat each hold the block from one acceptance
// to the next. The hold is set by the one shared multiplier, whose
// product is registered, and the one CORDIC add/shift step per cycle.
// The block takes a new beat only once the result beat has left, so an
// output stall lengthens the hold.
// Reset clears the pose, speeds and sequencer and loads register defaults.
// ---------------------------------------------------------------------------
`default_nettype none
module differential_drive_odometry (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ddo_in_if.sink     in_ch,
    ddo_out_if.source  out_ch,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_WAIT = 4'd2;
    localparam logic [3:0] S_CORD = 4'd3;
    localparam logic [3:0] S_OUT  = 4'd4;

    localparam int FB = ddo_pkg::FracBits;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  op_reg;
    logic [ddo_pkg::StepW-1:0] it_reg;

    logic [23:0] mpc_reg;
    logic [19:0] itw_reg;
    logic [16:0] fw_reg;

    logic        mode_reg;
    logic signed [23:0] lc_reg, rc_reg;
    logic [23:0] dt_reg;

    logic signed [47:0] x_acc, y_acc;
    logic [31:0] ang_acc;
    logic signed [31:0] lin_reg, rate_reg, left_reg, right_reg, llpf_reg, rlpf_reg;
    logic signed [31:0] sx_reg, sy_reg, sh_reg;
    logic signed [63:0] tmp_reg;
    logic signed [63:0] dist_reg;
    logic signed [63:0] cx_reg, cy_reg, z_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;

    ddo_mac u_mac (.clk(clk), .a(ma), .b(mb), .prod(prod));

    function automatic logic signed [63:0] rsh(input logic signed [65:0] v, input int n);
        logic signed [65:0] t;
        begin
            t = v + (66'sd1 <<< (n - 1));
            return 64'(t >>> n);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return 32'(v);
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        begin
            if (v > 64'sh00007FFFFFFFFFFF)
                return 48'sh7FFFFFFFFFFF;
            else if (v < -64'sh0000800000000000)
                return 48'sh800000000000;
            else
                return 48'(v);
        end
    endfunction

    logic [16:0] w_eff;
    assign w_eff = (fw_reg > 17'd65536) ? 17'd65536 : fw_reg;

    // Operand selection for the shared multiplier, by operation index.
    // The heading increment splits the turn angle into a low and a high
    // part so that each product fits the multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (mode_reg == 1'b0)
        begin
            case (op_reg)
                4'd0: begin ma = 33'(lc_reg); mb = $signed({9'd0, mpc_reg}); end
                4'd1: begin ma = 33'(rc_reg); mb = $signed({9'd0, mpc_reg}); end
                4'd2: begin ma = 33'(left_reg); mb = $signed({16'd0, w_eff}); end
                4'd3: begin ma = 33'(llpf_reg); mb = $signed(33'd65536 - 33'(w_eff)); end
                4'd4: begin ma = 33'(right_reg); mb = $signed({16'd0, w_eff}); end
                4'd5: begin ma = 33'(rlpf_reg); mb = $signed(33'd65536 - 33'(w_eff)); end
                4'd6: begin ma = 33'(tmp_reg); mb = $signed({13'd0, itw_reg}); end
                default: ;
            endcase
        end
        else
        begin
            case (op_reg)
                4'd0: begin ma = 33'(lin_reg); mb = $signed({9'd0, dt_reg}); end
                4'd1: begin ma = 33'(rate_reg); mb = $signed({9'd0, dt_reg}); end
                4'd2:
                begin
                    ma = $signed(33'(tmp_reg[FB-1:0]));
                    mb = 33'(ddo_pkg::RAD_TO_ANG);
                end
                4'd3: begin ma = 33'(tmp_reg >>> FB); mb = 33'(ddo_pkg::RAD_TO_ANG); end
                4'd4: begin ma = 33'(dist_reg); mb = 33'(ddo_pkg::GAIN_Q30); end
                default: ;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);

    always_comb
    begin
        out_ch.data.pos_x          = x_acc;
        out_ch.data.pos_y          = y_acc;
        out_ch.data.heading        = ang_acc;
        out_ch.data.step_x         = sx_reg;
        out_ch.data.step_y         = sy_reg;
        out_ch.data.step_heading   = sh_reg;
        out_ch.data.linear_speed   = lin_reg;
        out_ch.data.turn_rate      = rate_reg;
        out_ch.data.left_speed     = left_reg;
        out_ch.data.right_speed    = right_reg;
        out_ch.data.left_filtered  = llpf_reg;
        out_ch.data.right_filtered = rlpf_reg;
    end

    logic last_op;
    assign last_op = mode_reg ? (op_reg == 4'd4) : (op_reg == 4'd6);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_MUL;
            S_MUL:  state_next = S_WAIT;
            S_WAIT:
                if (last_op)
                    state_next = mode_reg ? S_CORD : S_OUT;
                else
                    state_next = S_MUL;
            S_CORD: if (it_reg == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1)) state_next = S_OUT;
            S_OUT:  if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer, datapath state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            it_reg    <= '0;
            mpc_reg   <= ddo_pkg::MPC_RESET;
            itw_reg   <= ddo_pkg::ITW_RESET;
            fw_reg    <= ddo_pkg::FW_RESET;
            x_acc <= '0; y_acc <= '0; ang_acc <= '0;
            lin_reg <= '0; rate_reg <= '0; left_reg <= '0; right_reg <= '0;
            llpf_reg <= '0; rlpf_reg <= '0;
            sx_reg <= '0; sy_reg <= '0; sh_reg <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ddo_pkg::REG_MPC: mpc_reg <= cfg_data;
                    ddo_pkg::REG_ITW: itw_reg <= cfg_data[19:0];
                    ddo_pkg::REG_FW:  fw_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        mode_reg <= in_ch.data.mode;
                        op_reg   <= '0;
                    end
                S_WAIT:
                begin
                    op_reg <= op_reg + 4'd1;
                    it_reg <= '0;
                    if (!mode_reg)
                    begin
                        case (op_reg)
                            4'd0: left_reg  <= sat32(rsh(prod, 40 - FB));
                            4'd1: right_reg <= sat32(rsh(prod, 40 - FB));
                            4'd2: tmp_reg   <= 64'(prod);
                            4'd3:
                            begin
                                llpf_reg <= 32'(rsh(66'(tmp_reg) + prod, 16));
                                tmp_reg  <= 64'(right_reg) - 64'(left_reg);
                                lin_reg  <= 32'(rsh(66'(left_reg) + 66'(right_reg), 1));
                            end
                            4'd4: dist_reg  <= 64'(prod);
                            4'd5:
                                rlpf_reg <= 32'(rsh(66'(dist_reg) + prod, 16));
                            default: rate_reg <= sat32(rsh(prod, 16));
                        endcase
                    end
                    else
                    begin
                        case (op_reg)
                            4'd0: dist_reg <= 64'(sat32(rsh(prod, 24)));
                            4'd1: tmp_reg  <= rsh(prod, 16);
                            // Low part of the turn angle, rounded into whole angle units.
                            4'd2: sh_reg <= 32'(rsh(prod, FB));
                            4'd3:
                            begin
                                // High part of the turn angle adds in whole units.
                                sh_reg <= sh_reg + 32'(prod);
                                // Fold the old heading into a half turn.
                                if ((ang_acc + 32'h40000000) >= 32'h80000000)
                                begin
                                    dist_reg <= -dist_reg;
                                    z_reg    <= 64'($signed(ang_acc + 32'h80000000));
                                end
                                else
                                    z_reg <= 64'($signed(ang_acc));
                            end
                            default:
                            begin
                                cx_reg <= rsh(prod, 30);
                                cy_reg <= '0;
                            end
                        endcase
                    end
                end
                S_CORD:
                begin
                    // One CORDIC micro-rotation per cycle.
                    it_reg <= it_reg + 1'b1;
                    if (z_reg >= 0)
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> it_reg);
                        cy_reg <= cy_reg + (cx_reg >>> it_reg);
                        z_reg  <= z_reg - 64'(ddo_pkg::atan_angle(5'(it_reg)));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> it_reg);
                        cy_reg <= cy_reg - (cx_reg >>> it_reg);
                        z_reg  <= z_reg + 64'(ddo_pkg::atan_angle(5'(it_reg)));
                    end
                    if (it_reg == ddo_pkg::StepW'(ddo_pkg::CordicSteps - 1))
                    begin
                        sx_reg  <= sat32(cx_reg - (z_reg >= 0 ? (cy_reg >>> it_reg)
                                                              : -(cy_reg >>> it_reg)));
                        sy_reg  <= sat32(cy_reg + (z_reg >= 0 ? (cx_reg >>> it_reg)
                                                              : -(cx_reg >>> it_reg)));
                        x_acc   <= sat48(64'(x_acc) + 64'(sat32(cx_reg - (z_reg >= 0 ?
                                   (cy_reg >>> it_reg) : -(cy_reg >>> it_reg)))));
                        y_acc   <= sat48(64'(y_acc) + 64'(sat32(cy_reg + (z_reg >= 0 ?
                                   (cx_reg >>> it_reg) : -(cx_reg >>> it_reg)))));
                        ang_acc <= ang_acc + sh_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Input fields are captured at acceptance.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            lc_reg <= in_ch.data.left_counts;
            rc_reg <= in_ch.data.right_counts;
            dt_reg <= in_ch.data.elapsed_time;
        end
    end

    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready during result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("double accept");

endmodule
`default_nettype wire

>>> dv/ddo_odometry_checker.sv
// ---------------------------------------------------------------------------
// ddo_odometry_checker: pose predictor and result comparator
// Watches the input, output and register ports of the odometry block. It
// keeps its own copy of the pose, speeds and registers, predicts every
// result beat and compares each field with the oldest prediction.
// ---------------------------------------------------------------------------
module ddo_odometry_checker (
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if           in_ch,
    ddo_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          fails,
    output int          pending
);

    // Binary-angle arctangent of 2^-i.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Register copies.
    logic [23:0] mpc_q;
    logic [19:0] itw_q;
    logic [16:0] fw_q;

    // Pose and speed copies.
    longint x_pos, y_pos;
    logic [31:0] head_ang;
    longint lin_v, turn_v, left_v, right_v, left_f, right_f;
    longint dx_last, dy_last, dh_last;

    ddo_pkg::out_beat_t pose_queue[$];

    // Right shift that rounds half up.
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    task automatic update_wheels(ddo_pkg::in_beat_t b);
        longint lc, rc, w;
        lc = longint'($signed(b.left_counts));
        rc = longint'($signed(b.right_counts));
        w  = (fw_q > 17'd65536) ? 65536 : longint'(fw_q);
        left_v  = clamp(round_shift(lc * longint'(mpc_q), 40 - ddo_pkg::FracBits), 32);
        right_v = clamp(round_shift(rc * longint'(mpc_q), 40 - ddo_pkg::FracBits), 32);
        left_f  = round_shift(w * left_v + (65536 - w) * left_f, 16);
        right_f = round_shift(w * right_v + (65536 - w) * right_f, 16);
        lin_v   = round_shift(left_v + right_v, 1);
        turn_v  = clamp(round_shift((right_v - left_v) * longint'(itw_q), 16), 32);
    endtask

    task automatic integrate_tick(ddo_pkg::in_beat_t b);
        longint dt, travel, rad, cx, cy, z, sx, sy;
        logic [31:0] dang, a;
        int s;
        dt     = longint'(b.elapsed_time);
        travel = clamp(round_shift(lin_v * dt, 24), 32);
        rad    = round_shift(turn_v * dt, 16);
        dang   = 32'(round_shift(rad * longint'(ddo_pkg::RAD_TO_ANG), ddo_pkg::FracBits));
        a      = head_ang;
        // Fold the heading into the half turn that the rotation covers.
        if (32'(a + 32'h40000000) >= 32'h80000000)
        begin
            travel = -travel;
            a      = a + 32'h80000000;
        end
        z  = longint'($signed(a));
        cx = round_shift(travel * longint'(ddo_pkg::GAIN_Q30), 30);
        cy = 0;
        for (int i = 0; i < ddo_pkg::CordicSteps; i++)
        begin
            s  = i & 31;
            sx = cy >>> s;
            sy = cx >>> s;
            if (z >= 0)
            begin
                cx = cx - sx;
                cy = cy + sy;
                z  = z - longint'(ATAN_TAB[s]);
            end
            else
            begin
                cx = cx + sx;
                cy = cy - sy;
                z  = z + longint'(ATAN_TAB[s]);
            end
        end
        dx_last  = clamp(cx, 32);
        dy_last  = clamp(cy, 32);
        dh_last  = longint'($signed(dang));
        x_pos    = clamp(x_pos + dx_last, 48);
        y_pos    = clamp(y_pos + dy_last, 48);
        head_ang = head_ang + dang;
    endtask

    function automatic ddo_pkg::out_beat_t pose_snapshot();
        ddo_pkg::out_beat_t r;
        r.pos_x          = 48'(x_pos);
        r.pos_y          = 48'(y_pos);
        r.heading        = head_ang;
        r.step_x         = 32'(dx_last);
        r.step_y         = 32'(dy_last);
        r.step_heading   = 32'(dh_last);
        r.linear_speed   = 32'(lin_v);
        r.turn_rate      = 32'(turn_v);
        r.left_speed     = 32'(left_v);
        r.right_speed    = 32'(right_v);
        r.left_filtered  = 32'(left_f);
        r.right_filtered = 32'(right_f);
        return r;
    endfunction

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        fails++;
    endtask

    task automatic compare_pose(ddo_pkg::out_beat_t g, ddo_pkg::out_beat_t e);
        if (g.pos_x !== e.pos_x) report("pos_x", g.pos_x, e.pos_x);
        if (g.pos_y !== e.pos_y) report("pos_y", g.pos_y, e.pos_y);
        if (g.heading !== e.heading) report("heading", g.heading, e.heading);
        if (g.step_x !== e.step_x) report("step_x", g.step_x, e.step_x);
        if (g.step_y !== e.step_y) report("step_y", g.step_y, e.step_y);
        if (g.step_heading !== e.step_heading)
            report("step_heading", g.step_heading, e.step_heading);
        if (g.linear_speed !== e.linear_speed)
            report("linear_speed", g.linear_speed, e.linear_speed);
        if (g.turn_rate !== e.turn_rate) report("turn_rate", g.turn_rate, e.turn_rate);
        if (g.left_speed !== e.left_speed)
            report("left_speed", g.left_speed, e.left_speed);
        if (g.right_speed !== e.right_speed)
            report("right_speed", g.right_speed, e.right_speed);
        if (g.left_filtered !== e.left_filtered)
            report("left_filtered", g.left_filtered, e.left_filtered);
        if (g.right_filtered !== e.right_filtered)
            report("right_filtered", g.right_filtered, e.right_filtered);
    endtask

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    // Track registers, predict on each input beat, compare on each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpc_q    = ddo_pkg::MPC_RESET;
            itw_q    = ddo_pkg::ITW_RESET;
            fw_q     = ddo_pkg::FW_RESET;
            x_pos    = 0;
            y_pos    = 0;
            head_ang = '0;
            lin_v    = 0;
            turn_v   = 0;
            left_v   = 0;
            right_v  = 0;
            left_f   = 0;
            right_f  = 0;
            dx_last  = 0;
            dy_last  = 0;
            dh_last  = 0;
            pose_queue.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ddo_pkg::REG_MPC: mpc_q = cfg_data;
                    ddo_pkg::REG_ITW: itw_q = cfg_data[19:0];
                    ddo_pkg::REG_FW:  fw_q  = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $display("unexpected result beat");
                    fails++;
                end
                else
                    compare_pose(out_ch.data, pose_queue.pop_front());
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.data.mode)
                    integrate_tick(in_ch.data);
                else
                    update_wheels(in_ch.data);
                pose_queue.push_back(pose_snapshot());
            end
            pending = pose_queue.size();
        end
    end

endmodule

>>> dv/tb_differential_drive_odometry.sv
// ---------------------------------------------------------------------------
// tb_differential_drive_odometry: odometry block regression
// Drives directed and random wheel and tick beats through several register
// settings and idle patterns; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_differential_drive_odometry;

    localparam int WatchLimit = 20000;
    localparam int Drain      = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    int          fails;
    int          pending;
    int          gap_pct;
    int          stall_pct;
    int          quiet_cycles;

    ddo_in_if  in_ch ();
    ddo_out_if out_ch ();

    differential_drive_odometry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ddo_odometry_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    // Result receiver stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles with no beat moving.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WatchLimit)
        begin
            $display("differential_drive_odometry regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Send one beat, holding valid high when there is no gap.
    task automatic send_beat(logic mode, logic [23:0] lc, logic [23:0] rc,
                             logic [23:0] dt);
        int  gap;
        logic taken;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{mode: mode, left_counts: lc, right_counts: rc,
                         elapsed_time: dt};
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Let the block drain before touching registers.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (Drain) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random beat: a wheel sample or a tick chosen at random with random
    // content, sometimes small speeds or short ticks.
    task automatic random_beat();
        logic [23:0] lc, rc, dt;
        lc = 24'($urandom());
        rc = 24'($urandom());
        dt = 24'($urandom());
        if ($urandom_range(3) == 0)
        begin
            lc = 24'($signed($urandom_range(4000)) - 2000);
            rc = 24'($signed($urandom_range(4000)) - 2000);
        end
        if ($urandom_range(2) == 0)
            dt = 24'($urandom_range(400000));
        send_beat(1'($urandom_range(1)), lc, rc, dt);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = ddo_pkg::REG_MPC;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default registers, field extremes and ignored fields.
        send_beat(1'b1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
        send_beat(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h123456);
        send_beat(1'b1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'h000000);
        send_beat(1'b0, 24'h800000, 24'h800000, 24'hFFFFFF);
        send_beat(1'b1, 24'hFFFFFF, 24'h000001, 24'h800000);
        send_beat(1'b0, 24'h000000, 24'h000000, 24'h000000);
        send_beat(1'b0, 24'hFFFFFF, 24'h000001, 24'h000000);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'h000001);
        settle();

        // Directed: large turns with the widest track factor, weight above one,
        // and an unknown register index.
        write_reg(ddo_pkg::REG_MPC, 24'hFFFFFF);
        write_reg(ddo_pkg::REG_ITW, 24'h0FFFFF);
        write_reg(ddo_pkg::REG_FW, 24'h01FFFF);
        write_reg(2'd3, 24'hFFFFFF);
        send_beat(1'b0, 24'h800000, 24'h7FFFFF, 24'h000000);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'hFFFFFF);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'h7FFFFF);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'hFFFFFF);
        settle();
        write_reg(ddo_pkg::REG_FW, 24'h010001);
        write_reg(ddo_pkg::REG_MPC, 24'h000000);
        write_reg(ddo_pkg::REG_ITW, 24'h000000);
        send_beat(1'b0, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'hFFFFFF);
        settle();
        write_reg(ddo_pkg::REG_FW, 24'h000000);
        write_reg(ddo_pkg::REG_MPC, 24'd615683);
        send_beat(1'b0, 24'h400000, 24'hC00000, 24'h000000);
        send_beat(1'b1, 24'h000000, 24'h000000, 24'h100000);
        settle();

        // Random: six segments over three idle patterns and varied registers.
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0: begin gap_pct = 27; stall_pct = 59; end
                1: begin gap_pct = 59; stall_pct = 27; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            case (seg)
                0: begin
                    write_reg(ddo_pkg::REG_MPC, 24'd615683);
                    write_reg(ddo_pkg::REG_ITW, 24'd119678);
                    write_reg(ddo_pkg::REG_FW, 24'd65536);
                end
                1: begin
                    write_reg(ddo_pkg::REG_MPC, 24'hFFFFFF);
                    write_reg(ddo_pkg::REG_ITW, 24'h0FFFFF);
                    write_reg(ddo_pkg::REG_FW, 24'd0);
                end
                2: begin
                    write_reg(ddo_pkg::REG_MPC, 24'd0);
                    write_reg(ddo_pkg::REG_ITW, 24'd0);
                    write_reg(ddo_pkg::REG_FW, 24'h01FFFF);
                end
                default: begin
                    write_reg(ddo_pkg::REG_MPC, 24'($urandom()));
                    write_reg(ddo_pkg::REG_ITW, 24'($urandom()));
                    write_reg(ddo_pkg::REG_FW, 24'($urandom()));
                    write_reg(2'd3, 24'($urandom()));
                end
            endcase
            for (int n = 0; n < 150; n++)
                random_beat();
            settle();
        end

        if (fails == 0)
            $display("differential_drive_odometry regression: pass");
        else
            $display("differential_drive_odometry regression: fail");
        $finish;
    end

endmodule
